/* rtl/blrt_pkg.sv */
// ----------------------------------------------------------------------------
// blrt_pkg
// Shared types and constants of the bytecode line run table.
// ----------------------------------------------------------------------------
package blrt_pkg;

    localparam int CODE_DEPTH = 4096;
    localparam int RUN_DEPTH  = 1024;
    localparam int LINE_BITS  = 24;

    localparam int CODE_AW = $clog2(CODE_DEPTH);
    localparam int CODE_CW = $clog2(CODE_DEPTH + 1);
    localparam int RUN_AW  = $clog2(RUN_DEPTH);
    localparam int RUN_CW  = $clog2(RUN_DEPTH + 1);

    localparam int OFF_W = 12;
    localparam int CMP_W = (CODE_CW > OFF_W) ? CODE_CW : OFF_W;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CODE_FULL = 3'd1,
        ST_RUN_FULL  = 3'd2,
        ST_RANGE     = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef logic [LINE_BITS-1:0] t_line;

    typedef struct packed {
        logic        action;
        logic [7:0]  code_byte;
        logic [23:0] line_number;
        logic [11:0] query_offset;
    } t_in;

    typedef struct packed {
        logic [23:0] found_line;
        logic [7:0]  found_byte;
        logic [12:0] stored_count;
        t_status     status;
    } t_out;

    typedef struct packed {
        logic [CODE_AW-1:0] start;
        t_line              line;
    } t_run;

    typedef struct packed {
        logic              start;
        logic [RUN_AW-1:0] last;
    } t_srch_ctl;

    typedef struct packed {
        logic  done;
        t_line line;
    } t_srch_sts;

endpackage

/* rtl/blrt_ram.sv */
// ----------------------------------------------------------------------------
// blrt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module blrt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/blrt_search.sv */
// ----------------------------------------------------------------------------
// blrt_search
// Binary search sequencer: finds the last run whose start does not exceed
// the query offset, one probe read and one compare per step, then reads
// that run's line.
// ----------------------------------------------------------------------------
module blrt_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  blrt_pkg::t_srch_ctl         i_ctl,
    input  logic [blrt_pkg::CODE_AW-1:0] i_query,
    input  blrt_pkg::t_run              i_rd_data,
    output logic [blrt_pkg::RUN_AW-1:0] o_rd_addr,
    output logic                        o_rd_en,
    output blrt_pkg::t_srch_sts         o_sts
);

    import blrt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_LINE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [RUN_AW-1:0]   r_lo, r_hi, r_mid;
    logic [CODE_AW-1:0]  r_query;
    logic [RUN_AW:0]     w_span;
    logic [RUN_AW-1:0]   w_mid;

    assign w_span = {1'b0, r_hi} - {1'b0, r_lo} + (RUN_AW+1)'(1);
    assign w_mid  = r_lo + RUN_AW'(w_span >> 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_ctl.start) n_state = S_PROBE;
            S_PROBE: n_state = (r_lo < r_hi) ? S_CMP : S_LINE;
            S_CMP:   n_state = S_PROBE;
            S_LINE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    r_lo    <= '0;
                    r_hi    <= i_ctl.last;
                    r_query <= i_query;
                end
            end
            S_PROBE: begin
                r_mid <= w_mid;
            end
            S_CMP: begin
                if (i_rd_data.start <= r_query) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid - RUN_AW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_rd_en    = (r_state == S_PROBE);
    assign o_rd_addr  = (r_lo < r_hi) ? w_mid : r_lo;
    assign o_sts.done = (r_state == S_LINE);
    assign o_sts.line = i_rd_data.line;

endmodule

/* rtl/bytecode_line_run_table_unit.sv */
// ----------------------------------------------------------------------------
// bytecode_line_run_table_unit
// Code byte store with a run-length table of source lines; appends bytes
// and looks up the byte and line of an offset by binary search.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------
//   input   | in        | i_in_valid / o_in_stall | i_in_data (t_in)
//   output  | out       | o_out_valid/ i_out_stall| o_out_data(t_out)
//
// An append or a failed lookup loads the result register at the input
// transfer, and the output register takes it once the output is free.
// A good lookup runs the search loop: one run memory read and one compare
// per halving step. One item is in work at a time; the output register
// frees the input side as soon as it is loaded, and a held output keeps
// the input stalled. Reset clears state, counts and output valid only;
// the memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module bytecode_line_run_table_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  blrt_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output blrt_pkg::t_out  o_out_data
);

    import blrt_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE   = 3'b001,
        T_SEARCH = 3'b010,
        T_DONE   = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CODE_CW-1:0]  r_byte_total;
    logic [RUN_CW-1:0]   r_run_total;
    t_line               r_last_line;
    t_out                r_res;
    t_out                r_out;
    logic                r_out_valid;

    logic                w_accept;
    logic                w_out_free;
    t_line               w_line;
    logic [CMP_W-1:0]    w_off;
    logic                w_code_full, w_run_full, w_new_run;
    t_status             w_app_status;
    logic                w_app_ok;
    logic                w_lkp_empty, w_lkp_range;
    logic                w_byte_we, w_run_we;
    t_run                w_run_wdata;
    logic [7:0]          w_byte_rdata;
    t_run                w_run_rdata;
    logic [RUN_AW-1:0]   w_run_raddr;
    logic                w_run_re;
    t_srch_ctl           w_ctl;
    t_srch_sts           w_sts;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_line     = LINE_BITS'(i_in_data.line_number);
    assign w_off      = CMP_W'(i_in_data.query_offset);

    assign w_code_full = (r_byte_total == CODE_CW'(CODE_DEPTH));
    assign w_run_full  = (r_run_total == RUN_CW'(RUN_DEPTH));
    assign w_new_run   = (r_run_total == '0) || (r_last_line != w_line);

    always_comb begin
        if (w_code_full) begin
            w_app_status = ST_CODE_FULL;
        end else if (w_new_run && w_run_full) begin
            w_app_status = ST_RUN_FULL;
        end else begin
            w_app_status = ST_OK;
        end
    end

    assign w_app_ok    = (w_app_status == ST_OK);
    assign w_lkp_empty = (r_run_total == '0);
    assign w_lkp_range = (w_off >= CMP_W'(r_byte_total));

    assign w_byte_we = w_accept && (i_in_data.action == ACT_APPEND) && w_app_ok;
    assign w_run_we  = w_byte_we && w_new_run;
    assign w_run_wdata.start = r_byte_total[CODE_AW-1:0];
    assign w_run_wdata.line  = w_line;

    assign w_ctl.start = w_accept && (i_in_data.action == ACT_LOOKUP)
                         && !w_lkp_empty && !w_lkp_range;
    assign w_ctl.last  = RUN_AW'(r_run_total - RUN_CW'(1));

    blrt_ram #(
        .DEPTH(CODE_DEPTH),
        .WIDTH(8)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (w_byte_we),
        .i_waddr (r_byte_total[CODE_AW-1:0]),
        .i_wdata (i_in_data.code_byte),
        .i_re    (w_ctl.start),
        .i_raddr (w_off[CODE_AW-1:0]),
        .o_rdata (w_byte_rdata)
    );

    blrt_ram #(
        .DEPTH(RUN_DEPTH),
        .WIDTH($bits(t_run))
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (w_run_we),
        .i_waddr (r_run_total[RUN_AW-1:0]),
        .i_wdata (w_run_wdata),
        .i_re    (w_run_re),
        .i_raddr (w_run_raddr),
        .o_rdata (w_run_rdata)
    );

    blrt_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_query   (w_off[CODE_AW-1:0]),
        .i_rd_data (w_run_rdata),
        .o_rd_addr (w_run_raddr),
        .o_rd_en   (w_run_re),
        .o_sts     (w_sts)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: begin
                if (w_ctl.start) begin
                    n_state = T_SEARCH;
                end else if (w_accept) begin
                    n_state = T_DONE;
                end
            end
            T_SEARCH: if (w_sts.done) n_state = T_DONE;
            T_DONE:   if (w_out_free) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_byte_total <= '0;
            r_run_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_byte_we) begin
                r_byte_total <= r_byte_total + CODE_CW'(1);
            end
            if (w_run_we) begin
                r_run_total <= r_run_total + RUN_CW'(1);
            end
            if (r_state == T_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_run_we) begin
            r_last_line <= w_line;
        end
        if (r_state == T_IDLE && w_accept) begin
            r_res.found_line <= '0;
            r_res.found_byte <= '0;
            if (i_in_data.action == ACT_APPEND) begin
                r_res.stored_count <= 13'(r_byte_total + CODE_CW'(w_app_ok));
                r_res.status       <= w_app_status;
            end else begin
                r_res.stored_count <= 13'(r_byte_total);
                if (w_lkp_empty) begin
                    r_res.status <= ST_EMPTY;
                end else if (w_lkp_range) begin
                    r_res.status <= ST_RANGE;
                end else begin
                    r_res.status <= ST_OK;
                end
            end
        end else if (r_state == T_SEARCH && w_sts.done) begin
            r_res.found_line <= 24'(w_sts.line);
            r_res.found_byte <= w_byte_rdata;
        end
        if (r_state == T_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != T_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* bench/tb_bytecode_line_run_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_bytecode_line_run_table_unit
// Self-checking bench for the bytecode line run table. A scoreboard predicts
// each result from its own copy of the byte store and line run table. It is
// driven by directed cases, random append runs and lookups, and a closing set
// of range-edge and random lookups. Both sides idle at random, the output
// holds off for a long stretch once, and the input pauses once until drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bytecode_line_run_table_unit;

    import blrt_pkg::*;

    localparam int RANDOM_ITEMS  = 810;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 15;

    class line_lookup_board;
        logic [7:0]  code_bytes [CODE_DEPTH];
        logic [11:0] run_starts [RUN_DEPTH];
        t_line       run_lines  [RUN_DEPTH];
        int unsigned runs_held;
        int unsigned bytes_held;
        t_out        awaited_results [$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned status_tally [5];

        function new();
            runs_held    = 0;
            bytes_held   = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void note_transfer_in(t_in item);
            t_out        exp;
            logic        fresh_run;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            exp        = '0;
            exp.status = ST_OK;
            if (item.action == ACT_APPEND) begin
                if (bytes_held >= CODE_DEPTH) begin
                    exp.status = ST_CODE_FULL;
                end else begin
                    if (runs_held == 0) begin
                        fresh_run = 1'b1;
                    end else begin
                        fresh_run = (run_lines[runs_held-1] != t_line'(item.line_number));
                    end
                    if (fresh_run && runs_held >= RUN_DEPTH) begin
                        exp.status = ST_RUN_FULL;
                    end else begin
                        code_bytes[bytes_held] = item.code_byte;
                        if (fresh_run) begin
                            run_starts[runs_held] = 12'(bytes_held);
                            run_lines[runs_held]  = t_line'(item.line_number);
                            runs_held++;
                        end
                        bytes_held++;
                    end
                end
            end else if (runs_held == 0) begin
                exp.status = ST_EMPTY;
            end else if (int'(item.query_offset) >= bytes_held) begin
                exp.status = ST_RANGE;
            end else begin
                lo = 0;
                hi = runs_held - 1;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 1) / 2;
                    if (run_starts[mid] <= item.query_offset) lo = mid;
                    else hi = mid - 1;
                end
                exp.found_line = run_lines[lo];
                exp.found_byte = code_bytes[item.query_offset];
            end
            exp.stored_count = 13'(bytes_held);
            status_tally[int'(exp.status)]++;
            awaited_results.push_back(exp);
        endfunction

        function void check_transfer_out(t_out got);
            t_out exp;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", got);
                mismatches++;
                return;
            end
            exp = awaited_results.pop_front();
            if (got.found_line !== exp.found_line) begin
                $error("found_line: expected %0d, got %0d", exp.found_line, got.found_line);
                mismatches++;
            end
            if (got.found_byte !== exp.found_byte) begin
                $error("found_byte: expected %0d, got %0d", exp.found_byte, got.found_byte);
                mismatches++;
            end
            if (got.stored_count !== exp.stored_count) begin
                $error("stored_count: expected %0d, got %0d",
                       exp.stored_count, got.stored_count);
                mismatches++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_stall;
    t_in    i_in_data   = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_out   o_out_data;

    logic        calm       = 1'b0;
    int unsigned hold_asks  = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned items_sent = 0;

    line_lookup_board board;

    bytecode_line_run_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            hold_seen   <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_transfer_out(o_out_data);
        end
    end

    task automatic send_item(input t_in item);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_transfer_in(item);
        items_sent++;
    endtask

    task automatic push_append(input logic [7:0] code_byte, input t_line line_no);
        t_in item;
        item.action       = ACT_APPEND;
        item.code_byte    = code_byte;
        item.line_number  = line_no;
        item.query_offset = 12'($urandom_range(0, 4095));
        send_item(item);
    endtask

    task automatic push_lookup(input logic [11:0] offset);
        t_in item;
        item.action       = ACT_LOOKUP;
        item.code_byte    = 8'($urandom_range(0, 255));
        item.line_number  = 24'($urandom_range(0, 24'hFFFFFF));
        item.query_offset = offset;
        send_item(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_line       cur_line;
        int unsigned base;
        int unsigned burst;
        int unsigned pick;
        logic        held;
        logic        paused;

        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, field extremes, run changes, range edges
        push_lookup(12'd0);
        push_lookup(12'd4095);
        push_append(8'h00, 24'h000000);
        push_append(8'hFF, 24'h000000);
        push_append(8'hA5, 24'hFFFFFF);
        push_append(8'h5A, 24'hFFFFFF);
        push_append(8'h3C, 24'h800001);
        push_append(8'hC3, 24'h000000);
        for (int k = 0; k < 6; k++) push_lookup(12'(k));
        push_lookup(12'd6);
        push_lookup(12'd4095);
        push_lookup(12'd2048);

        // random: append runs with drifting lines, lookups mostly in range
        base     = items_sent;
        cur_line = 24'd100;
        held     = 1'b0;
        paused   = 1'b0;
        while (items_sent - base < RANDOM_ITEMS) begin
            calm <= (items_sent - base >= 600) && (items_sent - base < 700);
            if (!held && items_sent - base >= 300) begin
                hold_asks <= hold_asks + 1;
                held = 1'b1;
            end
            if (!paused && items_sent - base >= 500) begin
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 3);
                if (pick == 3) cur_line = t_line'($urandom_range(0, 24'hFFFFFF));
                else if (pick != 0) cur_line = cur_line + t_line'($urandom_range(1, 3));
                burst = $urandom_range(1, 6);
                repeat (burst) push_append(8'($urandom_range(0, 255)), cur_line);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 8) push_lookup(12'($urandom_range(0, board.bytes_held - 1)));
                else if (pick == 8) push_lookup(12'(board.bytes_held));
                else push_lookup(12'($urandom_range(0, 4095)));
            end
        end
        calm <= 1'b0;

        // closing lookups around the fill level and the offset extremes, then random offsets
        push_lookup(12'(board.bytes_held - 1));
        push_lookup(12'(board.bytes_held));
        push_lookup(12'd4095);
        push_lookup(12'd0);
        repeat (20) push_lookup(12'($urandom_range(0, 4095)));

        wait_drained();

        $display("Covered %0d input transfers, %0d results checked", items_sent,
                 board.results_seen);
        $display("Status mix ok/code full/run full/range/empty: %0d/%0d/%0d/%0d/%0d",
                 board.status_tally[ST_OK], board.status_tally[ST_CODE_FULL],
                 board.status_tally[ST_RUN_FULL], board.status_tally[ST_RANGE],
                 board.status_tally[ST_EMPTY]);
        if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/blrt_pkg.sv
rtl/blrt_ram.sv
rtl/blrt_search.sv
rtl/bytecode_line_run_table_unit.sv
bench/tb_bytecode_line_run_table_unit.sv
